### design/assert_macros.svh
// Assertion macros shared by the packer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("packer assertion failed");
`define SSP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("packer assertion failed");
`else
`define SSP_ASSERT(lbl, prop)
`define SSP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### design/ssp_pkg.sv
// Types and constants of the seven-bit packer.
package ssp_pkg;

  localparam logic [7:0] END_MARKER = 8'hF7;
  localparam int         MAX_RESULTS = 4;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_CHECKSUM = 2'd1,
    KIND_END      = 2'd2
  } kind_t;

  // register index, taken from byte address bit 2
  localparam logic REG_CHECKSUM_SEED = 1'b0;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      out_kind;
  } result_t;

  // all results caused by one input beat
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [1:0]                last_idx;
  } entry_t;

  typedef struct packed {
    logic       wr;
    logic [7:0] value;
  } seed_wr_t;

endpackage

### design/ssp_in_if.sv
// Input byte channel.
interface ssp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

### design/ssp_out_if.sv
// Output group channel.
interface ssp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       last_result;

  modport source (output valid, out_byte, out_kind, last_result, input ready);
  modport sink (input valid, out_byte, out_kind, last_result, output ready);
endinterface

### design/ssp_front.sv
// Front end: accepts bytes, re-cuts bits into groups, builds one result entry per beat.
`include "assert_macros.svh"
module ssp_front import ssp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic [7:0] seed,
  input  seed_wr_t   seed_wr,
  output logic       push,
  output entry_t     push_entry,
  input  logic       q_not_full
);

  logic [5:0]  residual_bits;
  logic [2:0]  bit_count;
  logic [7:0]  running_sum;
  logic [5:0]  residual_bits_next;
  logic [2:0]  bit_count_next;
  logic [7:0]  running_sum_next;

  logic [13:0] acc;
  logic [13:0] acc_shift;
  logic [3:0]  total;
  logic [3:0]  sh;
  logic        two;
  logic [2:0]  rem;
  logic [5:0]  mask;
  logic [5:0]  rem_bits;
  logic [6:0]  g0;
  logic [6:0]  g1;
  logic [6:0]  pad;
  logic        has_pad;
  logic [7:0]  s1;
  logic [7:0]  s2;
  logic [7:0]  s3;
  logic [6:0]  chk;
  logic [1:0]  base;
  logic        accept;

  assign in_ready = q_not_full;
  assign push     = in_valid;
  assign accept   = in_valid && in_ready;

  always_comb begin
    acc       = {residual_bits, data_byte};
    total     = {1'b0, bit_count} + 4'd8;
    sh        = total - 4'd7;
    acc_shift = acc >> sh;
    g0        = acc_shift[6:0];
    two       = (bit_count == 3'd6);
    g1        = acc[6:0];
    rem       = two ? 3'd0 : bit_count + 3'd1;
    mask      = 6'((7'd1 << rem) - 7'd1);
    rem_bits  = acc[5:0] & mask;
    pad       = {1'b0, rem_bits} << (3'd7 - rem);
    has_pad   = last_byte && (rem != 3'd0);
    s1        = running_sum + {1'b0, g0};
    s2        = two ? s1 + {1'b0, g1} : s1;
    s3        = has_pad ? s2 + {1'b0, pad} : s2;
    chk       = 7'(8'd0 - s3);
    base      = (two || has_pad) ? 2'd2 : 2'd1;

    push_entry = '0;
    push_entry.res[0] = '{out_byte: {1'b0, g0}, out_kind: KIND_DATA};
    if (two) begin
      push_entry.res[1] = '{out_byte: {1'b0, g1}, out_kind: KIND_DATA};
    end
    if (last_byte) begin
      if (has_pad) begin
        push_entry.res[1] = '{out_byte: {1'b0, pad}, out_kind: KIND_DATA};
      end
      push_entry.res[base]         = '{out_byte: {1'b0, chk}, out_kind: KIND_CHECKSUM};
      push_entry.res[base + 2'd1]  = '{out_byte: END_MARKER, out_kind: KIND_END};
      push_entry.last_idx          = base + 2'd1;
    end else begin
      push_entry.last_idx = two ? 2'd1 : 2'd0;
    end

    residual_bits_next = residual_bits;
    bit_count_next     = bit_count;
    running_sum_next   = running_sum;
    priority if (seed_wr.wr) begin
      running_sum_next = running_sum - seed + seed_wr.value;
    end else if (accept) begin
      if (last_byte) begin
        residual_bits_next = '0;
        bit_count_next     = '0;
        running_sum_next   = seed;
      end else begin
        residual_bits_next = rem_bits;
        bit_count_next     = rem;
        running_sum_next   = s3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      residual_bits <= '0;
      bit_count     <= '0;
      running_sum   <= '0;
    end else begin
      residual_bits <= residual_bits_next;
      bit_count     <= bit_count_next;
      running_sum   <= running_sum_next;
    end
  end

  `SSP_ASSERT(a_count_range, (bit_count <= 3'd6))
  `SSP_ASSERT(a_residual_fits, ((residual_bits >> bit_count) == 6'd0))
  `SSP_ASSERT(a_last_clears, (accept && last_byte && !seed_wr.wr |=> bit_count == 3'd0))

endmodule

### design/ssp_queue.sv
// Short entry queue between the front end and the output sequencer.
`include "assert_macros.svh"
module ssp_queue import ssp_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   not_full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign not_full  = (count != CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `SSP_ASSERT(a_count_bound, (count <= CNT_W'(DEPTH)))
  `SSP_ASSERT(a_pop_nonempty, (pop |-> not_empty))

endmodule

### design/ssp_back.sv
// Output sequencer: sends the results of each queued entry one beat at a time.
`include "assert_macros.svh"
module ssp_back import ssp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  entry_t     head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       last_result
);

  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load    = q_valid && (!out_valid || out_ready);
  assign at_last = (idx == head.last_idx);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= head.res[idx].out_byte;
      out_kind    <= head.res[idx].out_kind;
      last_result <= at_last;
    end
  end

  `SSP_ASSERT(a_pop_marks_last, (pop |=> out_valid && last_result))

endmodule

### design/sysex_seven_bit_packer.sv
// Top level of the seven-bit system-exclusive packer.
//
// byte_stream carries raw bytes (data_byte) with last_byte marking the end of
// a block. group_stream carries results: 7-bit data groups (out_kind 0), the
// 7-bit checksum (1) and the 0xF7 end marker (2); last_result flags the final
// beat caused by an input beat. A byte gives one or two groups; a last byte
// adds a padded group when bits remain, then checksum and end marker.
// The front end turns each accepted byte into one queue entry; the output
// sequencer sends one result beat per cycle while the receiver is ready; the
// first result is registered in the queue entry and then in the output register,
// and an item has 1 to 4 results (about 8/7 on average inside a block).
// The front end keeps taking bytes while the entry queue has room; a stalled
// receiver holds the output register and fills the queue, then byte_stream
// ready drops. Reset clears bit state, the sum and the seed to zero and empties
// the queue. The checksum seed lives at APB byte address 0; write it while idle.
module sysex_seven_bit_packer import ssp_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  ssp_in_if.sink      byte_stream,
  ssp_out_if.source   group_stream,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] checksum_seed;
  seed_wr_t   seed_wr;
  logic       push;
  entry_t     push_entry;
  logic       q_not_full;
  logic       q_not_empty;
  logic       pop;
  entry_t     head;

  assign pready        = 1'b1;
  assign seed_wr.wr    = psel && penable && pwrite && (paddr[2] == REG_CHECKSUM_SEED);
  assign seed_wr.value = pwdata[7:0];
  assign prdata        = (paddr[2] == REG_CHECKSUM_SEED) ? {24'd0, checksum_seed} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_seed <= '0;
    end else if (seed_wr.wr) begin
      checksum_seed <= seed_wr.value;
    end
  end

  ssp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (byte_stream.valid),
    .in_ready   (byte_stream.ready),
    .data_byte  (byte_stream.data_byte),
    .last_byte  (byte_stream.last_byte),
    .seed       (checksum_seed),
    .seed_wr    (seed_wr),
    .push       (push),
    .push_entry (push_entry),
    .q_not_full (q_not_full)
  );

  ssp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .not_full   (q_not_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  ssp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (group_stream.valid),
    .out_ready   (group_stream.ready),
    .out_byte    (group_stream.out_byte),
    .out_kind    (group_stream.out_kind),
    .last_result (group_stream.last_result)
  );

endmodule

### test/group_stream_checker.sv
// Checker that predicts and compares the packed group stream of the seven-bit packer.
module group_stream_checker import ssp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ssp_in_if           byte_mon,
  ssp_out_if          group_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          groups_outstanding
);

  typedef struct packed {
    logic [7:0] value;
    kind_t      kind;
    logic       ends_item;
  } group_t;

  group_t     groups_due[$];
  logic [7:0] seed_value;
  logic [7:0] running_sum;
  logic [5:0] residue;
  logic [2:0] residue_count;
  int         mismatches = 0;
  int         due_count = 0;

  assign fail_count = mismatches;
  assign groups_outstanding = due_count;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // cut one byte into 7-bit groups, msb first; close the packet on the last byte
  task automatic pack_byte(input logic [7:0] data, input logic last_in);
    logic [13:0] acc;
    int          nbits;
    logic [6:0]  grp;
    group_t      res[4];
    int          n;
    n = 0;
    acc = {residue, data};
    nbits = int'(residue_count) + 8;
    while (nbits >= 7) begin
      grp = acc[nbits-1 -: 7];
      nbits -= 7;
      running_sum = running_sum + {1'b0, grp};
      res[n] = '{value: {1'b0, grp}, kind: KIND_DATA, ends_item: 1'b0};
      n++;
    end
    acc = acc & ((14'd1 << nbits) - 14'd1);
    if (last_in) begin
      if (nbits > 0) begin
        grp = 7'(acc << (7 - nbits));
        running_sum = running_sum + {1'b0, grp};
        res[n] = '{value: {1'b0, grp}, kind: KIND_DATA, ends_item: 1'b0};
        n++;
      end
      res[n] = '{value: {1'b0, 7'(8'd0 - running_sum)}, kind: KIND_CHECKSUM, ends_item: 1'b0};
      n++;
      res[n] = '{value: END_MARKER, kind: KIND_END, ends_item: 1'b0};
      n++;
      residue = '0;
      residue_count = '0;
      running_sum = seed_value;
    end else begin
      residue = acc[5:0];
      residue_count = 3'(nbits);
    end
    res[n-1].ends_item = 1'b1;
    for (int i = 0; i < n; i++) groups_due.insert(groups_due.size(), res[i]);
  endtask

  task automatic check_group();
    group_t due;
    if (groups_due.size() == 0) begin
      report_mismatch("unexpected beat, out_byte", group_mon.out_byte, 0);
    end else begin
      due = groups_due.pop_front();
      if (group_mon.out_byte !== due.value)
        report_mismatch("out_byte", group_mon.out_byte, due.value);
      if (group_mon.out_kind !== due.kind)
        report_mismatch("out_kind", group_mon.out_kind, due.kind);
      if (group_mon.last_result !== due.ends_item)
        report_mismatch("last_result", group_mon.last_result, due.ends_item);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      seed_value = '0;
      running_sum = '0;
      residue = '0;
      residue_count = '0;
      groups_due.delete();
    end else begin
      if (psel && penable && pready && paddr[2] == REG_CHECKSUM_SEED) begin
        if (pwrite) begin
          running_sum = running_sum - seed_value + pwdata[7:0];
          seed_value = pwdata[7:0];
        end else if (prdata !== {24'd0, seed_value}) begin
          report_mismatch("checksum_seed readback", prdata, seed_value);
        end
      end
      if (group_mon.valid && group_mon.ready) check_group();
      if (byte_mon.valid && byte_mon.ready) pack_byte(byte_mon.data_byte, byte_mon.last_byte);
    end
    due_count <= groups_due.size();
  end

endmodule

### test/testbench.sv
// Top of the seven-bit packer testbench: clock, reset, stimulus, receiver and verdict.
module testbench;
  import ssp_pkg::*;

  localparam logic [2:0] SEED_ADDR     = {REG_CHECKSUM_SEED, 2'b00};
  localparam logic [2:0] UNMAPPED_ADDR = {~REG_CHECKSUM_SEED, 2'b00};
  localparam int         LONG_HOLD     = 200;
  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         PHASE_BYTES   = 38;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          groups_outstanding;
  int          idle_in = 0;
  int          idle_out = 0;
  int          hold_seq = 0;
  int          hold_seen = 0;
  int          cycles = 0;

  ssp_in_if  byte_stream();
  ssp_out_if group_stream();

  sysex_seven_bit_packer dut (
    .clk          (clk),
    .rst          (rst),
    .byte_stream  (byte_stream),
    .group_stream (group_stream),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  group_stream_checker checker_i (
    .clk                (clk),
    .rst                (rst),
    .byte_mon           (byte_stream),
    .group_mon          (group_stream),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .fail_count         (fail_count),
    .groups_outstanding (groups_outstanding)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    group_stream.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        group_stream.ready <= 1'b0;
      end else if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        group_stream.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        group_stream.ready <= ($urandom_range(99) >= idle_out);
      end
    end
  end

  task automatic send_beat(input logic [7:0] data, input logic last_in);
    while ($urandom_range(99) < idle_in) begin
      byte_stream.valid <= 1'b0;
      @(posedge clk);
    end
    byte_stream.valid <= 1'b1;
    byte_stream.data_byte <= data;
    byte_stream.last_byte <= last_in;
    do @(posedge clk); while (!byte_stream.ready);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (groups_outstanding != 0);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // drain, write, read back
  task automatic write_seed(input logic [2:0] addr, input logic [31:0] value);
    byte_stream.valid <= 1'b0;
    wait_drained();
    apb_access(1'b1, addr, value);
    apb_access(1'b0, SEED_ADDR, 32'd0);
  endtask

  initial begin
    int block_left;
    block_left = 0;
    byte_stream.valid <= 1'b0;
    byte_stream.data_byte <= '0;
    byte_stream.last_byte <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_in = 24;
    idle_out = 79;
    // seven bytes fill eight groups exactly: no padded group
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'h7F, 1'b0);
    send_beat(8'hAA, 1'b0);
    send_beat(8'h55, 1'b1);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h12, 1'b0);
    send_beat(8'h34, 1'b0);
    send_beat(8'h00, 1'b1);
    write_seed(SEED_ADDR, 32'hFFFF_FFFF);
    send_beat(8'hFE, 1'b0);
    send_beat(8'h01, 1'b1);
    write_seed(UNMAPPED_ADDR, 32'h0000_005A);
    send_beat(8'hC3, 1'b0);
    send_beat(8'h3C, 1'b0);
    // seed change with a packet still open
    write_seed(SEED_ADDR, 32'h0000_0080);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b1);
    write_seed(SEED_ADDR, 32'h0000_0000);

    for (int ph = 0; ph < 3; ph++) begin
      idle_in = (ph == 0) ? 24 : (ph == 1) ? 79 : 0;
      idle_out = (ph == 0) ? 79 : (ph == 1) ? 24 : 0;
      write_seed(SEED_ADDR, $urandom());
      if (ph == 2) hold_seq <= hold_seq + 1;
      for (int n = 0; n < PHASE_BYTES; n++) begin
        if (block_left == 0)
          block_left = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
        block_left--;
        send_beat(8'($urandom_range(255)), block_left == 0);
      end
    end

    byte_stream.valid <= 1'b0;
    wait_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && groups_outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
